// File: design/psrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psrp_pkg
// Shared constants, types and hex helpers for the power supply reply parser.
// ----------------------------------------------------------------------------
package psrp_pkg;

   localparam int FRAME_BYTES_DEF = 64;

   // byte offsets inside the reply frame
   localparam int POS_START     = 0;
   localparam int POS_RETCODE   = 8;
   localparam int POS_CMD_HI    = 11;
   localparam int POS_CMD_LO    = 12;
   localparam int POS_STATUS    = 17;
   localparam int POS_STATUS_LS = 20;
   localparam int POS_READING   = 23;
   localparam int POS_READ_LS   = 38;

   localparam int MIN_HEADER_LEN   = 14;
   localparam int MIN_READBACK_LEN = 39;

   localparam logic [7:0] CHR_TILDE = 8'h7E;
   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] CHR_ONE   = 8'h31;
   localparam logic [7:0] CHR_A_UC  = 8'h41;

   // outcome codes
   localparam logic [2:0] OUT_UPDATED    = 3'd0;
   localparam logic [2:0] OUT_OTHER_CMD  = 3'd1;
   localparam logic [2:0] OUT_BAD_HEADER = 3'd2;
   localparam logic [2:0] OUT_DEV_ERROR  = 3'd3;
   localparam logic [2:0] OUT_SHORT_READ = 3'd4;

   // status word bits
   localparam int ST_ON_BIT    = 14;
   localparam int ST_FAULT_BIT = 15;
   localparam int ST_LOAD_BIT  = 11;
   localparam int ST_WATER_BIT = 9;
   localparam int ST_IGBT_BIT  = 10;
   localparam int ST_DOOR_BIT  = 6;

   typedef logic [7:0] char_type;

   typedef struct packed {
      logic [2:0]  outcome;
      logic        update;
      logic [31:0] current;
      logic [31:0] voltage;
      logic [5:0]  flags;
   } decode_type;

   // {valid, value} of one ascii hex digit
   function automatic logic [4:0] hex_digit(input char_type c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   // digits taken up to the first non-hex character
   function automatic logic [31:0] parse_hex8(input char_type [7:0] s);
      logic [31:0] v;
      logic        run;
      logic [4:0]  d;
      v   = 32'd0;
      run = 1'b1;
      for (int i = 0; i < 8; i++) begin
         d = hex_digit(s[i]);
         if (run && d[4]) begin
            v = {v[27:0], d[3:0]};
         end else begin
            run = 1'b0;
         end
      end
      return v;
   endfunction

   function automatic logic [15:0] parse_hex4(input char_type [3:0] s);
      logic [15:0] v;
      logic        run;
      logic [4:0]  d;
      v   = 16'd0;
      run = 1'b1;
      for (int i = 0; i < 4; i++) begin
         d = hex_digit(s[i]);
         if (run && d[4]) begin
            v = {v[11:0], d[3:0]};
         end else begin
            run = 1'b0;
         end
      end
      return v;
   endfunction

endpackage
`default_nettype wire

// File: design/power_supply_reply_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// power_supply_reply_parser
// Collects an ascii power supply reply word by word and decodes it at the
// last word into an outcome plus stored current, voltage and status flags.
// ----------------------------------------------------------------------------
// Takes one reply byte per clock unless a frame's last word waits for a busy
// result register: each accepted word sits in an input register, where it is
// captured into the frame state and, on the last word of a frame, the frame is
// checked and decoded into the result register, which a last word thus reaches
// through the input register. Words that close no frame give no result; the
// output register lets next-frame bytes in while a result waits to be taken.
module power_supply_reply_parser #(
   parameter int FRAME_BYTES = psrp_pkg::FRAME_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_outcome,
   output logic [31:0]      rsp_current_bits,
   output logic [31:0]      rsp_voltage_bits,
   output logic [5:0]       rsp_status_flags
);

   localparam int POS_W = $clog2(FRAME_BYTES + 1);

   // input register
   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;
   logic       s1_go;
   logic       out_free;

   // frame state
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic                      zero_ff, zero_in;
   psrp_pkg::char_type [3:0]  hdr_ff, hdr_in;
   psrp_pkg::char_type [3:0]  stat_ff, stat_in;
   psrp_pkg::char_type [15:0] read_ff, read_in;
   logic [POS_W-1:0]          offset;
   logic [POS_W-1:0]          rd_offset;

   // stored readback
   logic [31:0] cur_ff;
   logic [31:0] volt_ff;
   logic [5:0]  flags_ff;

   // result register
   logic        rsp_valid_ff;
   logic [2:0]  outcome_ff;
   logic [31:0] cur_out_ff;
   logic [31:0] volt_out_ff;
   logic [5:0]  flags_out_ff;

   psrp_pkg::decode_type dec;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_go     = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_ready = !s1_valid_ff || s1_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_rx_byte;
         s1_last_ff <= req_last_byte;
      end
   end

   // capture of the registered word into the frame state
   always_comb begin
      pos_in    = pos_ff;
      zero_in   = zero_ff;
      hdr_in    = hdr_ff;
      stat_in   = stat_ff;
      read_in   = read_ff;
      offset    = pos_ff - POS_W'(psrp_pkg::POS_STATUS);
      rd_offset = pos_ff - POS_W'(psrp_pkg::POS_READING);
      if (!zero_ff) begin
         if (s1_byte_ff == 8'd0) begin
            zero_in = 1'b1;
         end else if (pos_ff < POS_W'(FRAME_BYTES)) begin
            pos_in = pos_ff + POS_W'(1);
            if (pos_ff == POS_W'(psrp_pkg::POS_START)) begin
               hdr_in[0] = s1_byte_ff;
            end else if (pos_ff == POS_W'(psrp_pkg::POS_RETCODE)) begin
               hdr_in[1] = s1_byte_ff;
            end else if (pos_ff == POS_W'(psrp_pkg::POS_CMD_HI)) begin
               hdr_in[2] = s1_byte_ff;
            end else if (pos_ff == POS_W'(psrp_pkg::POS_CMD_LO)) begin
               hdr_in[3] = s1_byte_ff;
            end else if (pos_ff >= POS_W'(psrp_pkg::POS_STATUS) &&
                         pos_ff <= POS_W'(psrp_pkg::POS_STATUS_LS)) begin
               stat_in[offset[1:0]] = s1_byte_ff;
            end else if (pos_ff >= POS_W'(psrp_pkg::POS_READING) &&
                         pos_ff <= POS_W'(psrp_pkg::POS_READ_LS)) begin
               read_in[rd_offset[3:0]] = s1_byte_ff;
            end
         end
      end
   end

   psrp_decode #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_decode (
      .header_chars  (hdr_in),
      .status_chars  (stat_in),
      .reading_chars (read_in),
      .frame_len     (pos_in),
      .result        (dec)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         zero_ff  <= 1'b0;
         hdr_ff   <= '0;
         stat_ff  <= '0;
         read_ff  <= '0;
         cur_ff   <= '0;
         volt_ff  <= '0;
         flags_ff <= '0;
      end else if (s1_go) begin
         hdr_ff  <= hdr_in;
         stat_ff <= stat_in;
         read_ff <= read_in;
         if (s1_last_ff) begin
            pos_ff  <= '0;
            zero_ff <= 1'b0;
            if (dec.update) begin
               cur_ff   <= dec.current;
               volt_ff  <= dec.voltage;
               flags_ff <= dec.flags;
            end
         end else begin
            pos_ff  <= pos_in;
            zero_ff <= zero_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_go && s1_last_ff) begin
         outcome_ff   <= dec.outcome;
         cur_out_ff   <= dec.update ? dec.current : cur_ff;
         volt_out_ff  <= dec.update ? dec.voltage : volt_ff;
         flags_out_ff <= dec.update ? dec.flags : flags_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_outcome      = outcome_ff;
   assign rsp_current_bits = cur_out_ff;
   assign rsp_voltage_bits = volt_out_ff;
   assign rsp_status_flags = flags_out_ff;

   // a shown result always matches the stored readback
   a_rsp_matches_store: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (cur_out_ff == cur_ff && volt_out_ff == volt_ff &&
                        flags_out_ff == flags_ff))
      else $error("result differs from stored readback");

   // a new result only follows a last word leaving the input register
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_last_ff) |=> rsp_valid_ff)
      else $error("frame end gave no result");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_last_ff) |=> (pos_ff == '0 && !zero_ff))
      else $error("frame state not cleared at frame end");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(FRAME_BYTES))
      else $error("byte position beyond frame size");

   a_store_only_on_update: assert property (@(posedge clock) disable iff (reset)
      !(s1_go && s1_last_ff && dec.update) |=> $stable(cur_ff) && $stable(volt_ff))
      else $error("readback changed without an updating frame");

endmodule
`default_nettype wire

// File: design/psrp_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psrp_decode
// Frame checks and field decode for one completed reply frame.
// ----------------------------------------------------------------------------
module psrp_decode #(
   parameter int FRAME_BYTES = psrp_pkg::FRAME_BYTES_DEF
) (
   input  wire psrp_pkg::char_type [3:0]              header_chars,
   input  wire psrp_pkg::char_type [3:0]              status_chars,
   input  wire psrp_pkg::char_type [15:0]             reading_chars,
   input  wire logic [$clog2(FRAME_BYTES + 1) - 1:0]  frame_len,
   output psrp_pkg::decode_type                       result
);

   localparam int LEN_W = $clog2(FRAME_BYTES + 1);

   psrp_pkg::char_type [7:0] cur_order;
   psrp_pkg::char_type [7:0] volt_order;
   logic [15:0]              status_word;

   // byte pairs taken in reverse order
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         cur_order[2*k]      = reading_chars[6 - 2*k];
         cur_order[2*k + 1]  = reading_chars[7 - 2*k];
         volt_order[2*k]     = reading_chars[14 - 2*k];
         volt_order[2*k + 1] = reading_chars[15 - 2*k];
      end
   end

   assign status_word = psrp_pkg::parse_hex4(status_chars);

   always_comb begin
      result.current = psrp_pkg::parse_hex8(cur_order);
      result.voltage = psrp_pkg::parse_hex8(volt_order);
      result.flags   = {status_word[psrp_pkg::ST_DOOR_BIT],
                        status_word[psrp_pkg::ST_IGBT_BIT],
                        status_word[psrp_pkg::ST_WATER_BIT],
                        status_word[psrp_pkg::ST_LOAD_BIT],
                        status_word[psrp_pkg::ST_FAULT_BIT],
                        ~status_word[psrp_pkg::ST_ON_BIT]};
      result.update  = 1'b0;
      if (header_chars[0] != psrp_pkg::CHR_TILDE ||
          frame_len < LEN_W'(psrp_pkg::MIN_HEADER_LEN)) begin
         result.outcome = psrp_pkg::OUT_BAD_HEADER;
      end else if (header_chars[1] != psrp_pkg::CHR_ZERO) begin
         result.outcome = psrp_pkg::OUT_DEV_ERROR;
      end else if (header_chars[2] != psrp_pkg::CHR_ONE ||
                   header_chars[3] != psrp_pkg::CHR_A_UC) begin
         result.outcome = psrp_pkg::OUT_OTHER_CMD;
      end else if (frame_len < LEN_W'(psrp_pkg::MIN_READBACK_LEN)) begin
         result.outcome = psrp_pkg::OUT_SHORT_READ;
      end else begin
         result.outcome = psrp_pkg::OUT_UPDATED;
         result.update  = 1'b1;
      end
   end

endmodule
`default_nettype wire
